// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define STT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/stt_pkg.sv =====
// ---------------------------------------------------------------------------
// Source text tokenizer package
// Shared types, token kinds, reserved word table and record builders.
// ---------------------------------------------------------------------------
package stt_pkg;

    localparam int MAX_TEXT_BYTES_DEF = 64;
    localparam int LINE_BITS_DEF      = 16;
    localparam int QUEUE_DEPTH_DEF    = 4;

    localparam int NUM_WORDS    = 10;
    localparam int NUM_KEYWORDS = 7;
    localparam int RECS_PER_ITEM = 3;

    localparam logic [2:0] KIND_IDENT    = 3'd0;
    localparam logic [2:0] KIND_KEYWORD  = 3'd1;
    localparam logic [2:0] KIND_TYPE     = 3'd2;
    localparam logic [2:0] KIND_NUMBER   = 3'd3;
    localparam logic [2:0] KIND_STRING   = 3'd4;
    localparam logic [2:0] KIND_OPERATOR = 3'd5;
    localparam logic [2:0] KIND_SYMBOL   = 3'd6;
    localparam logic [2:0] KIND_EOF      = 3'd7;

    localparam logic REC_TEXT = 1'b0;
    localparam logic REC_END  = 1'b1;

    localparam logic [7:0] WORD_TEXT [NUM_WORDS][8] = '{
        '{"t", "a", "m", "p", "i", "l", 8'h00, 8'h00},
        '{"j", "i", "k", "a", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "e", "l", "a", "m", "a", 8'h00, 8'h00},
        '{"f", "u", "n", "g", "s", "i", 8'h00, 8'h00},
        '{"b", "e", "n", "a", "r", 8'h00, 8'h00, 8'h00},
        '{"s", "a", "l", "a", "h", 8'h00, 8'h00, 8'h00},
        '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00}
    };

    localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
        3'd6, 3'd4, 3'd4, 3'd6, 3'd6, 3'd5, 3'd5, 3'd6, 3'd3, 3'd6
    };

    typedef struct packed {
        logic [7:0] input_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic        record_type;
        logic [7:0]  text_byte;
        logic [2:0]  token_kind;
        logic [5:0]  token_length;
        logic [3:0]  reserved_index;
        logic [15:0] line_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]                         count;
        out_item_t [RECS_PER_ITEM-1:0]      recs;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic out_item_t make_text(input logic [7:0] ch, input logic [15:0] line);
        out_item_t r;
        r                = '0;
        r.record_type    = REC_TEXT;
        r.text_byte      = ch;
        r.line_count     = line;
        return r;
    endfunction

    function automatic out_item_t make_end(input logic [2:0] kind, input logic [5:0] len,
                                           input logic [3:0] idx, input logic [15:0] line);
        out_item_t r;
        r                = '0;
        r.record_type    = REC_END;
        r.token_kind     = kind;
        r.token_length   = len;
        r.reserved_index = idx;
        r.line_count     = line;
        return r;
    endfunction

endpackage

// ===== rtl/core/stt_front.sv =====
// ---------------------------------------------------------------------------
// Tokenizer front end
// Lexer state machine: takes one byte per transfer and builds the bundle of
// up to three records it causes.
// ---------------------------------------------------------------------------
module stt_front
    import stt_pkg::*;
#(
    parameter int MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF,
    parameter int LINE_BITS      = LINE_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_ready,
    input  in_item_t src_data,
    input  logic     q_full,
    output logic     q_push,
    output bundle_t  q_bundle
);

    localparam int LEN_W = $clog2(MAX_TEXT_BYTES);
    localparam int CAP   = MAX_TEXT_BYTES - 1;

    localparam logic [2:0] M_IDLE     = 3'd0;
    localparam logic [2:0] M_IDENT    = 3'd1;
    localparam logic [2:0] M_NUMBER   = 3'd2;
    localparam logic [2:0] M_STRING   = 3'd3;
    localparam logic [2:0] M_ESCAPE   = 3'd4;
    localparam logic [2:0] M_OPERATOR = 3'd5;
    localparam logic [2:0] M_COMMENT  = 3'd6;

    logic [2:0]           mode_reg, mode_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [7:0]           op_reg, op_next;
    logic [NUM_WORDS-1:0] cand_reg, cand_next;
    logic [LINE_BITS-1:0] line_reg, line_next;

    logic                 accept;
    logic [7:0]           c;
    logic                 pre_close, start_run, put_req, post_close, line_inc, eof, ident_step;
    logic [2:0]           pre_kind, post_kind;
    logic [3:0]           pre_idx;
    logic [7:0]           put_char;
    logic                 id_hit;
    logic [2:0]           id_kind;
    logic [3:0]           id_idx;
    logic [LEN_W-1:0]     len_base, len_after;
    logic                 put_ok;
    logic [NUM_WORDS-1:0] cand_base, cand_mask;
    logic [31:0]          line_wide, pre_len_wide, post_len_wide;
    logic [1:0]           n;
    bundle_t              bundle;

    assign c         = src_data.input_byte;
    assign src_ready = !q_full;
    assign accept    = src_valid && src_ready;

    always_comb
    begin
        id_hit  = 1'b0;
        id_kind = KIND_IDENT;
        id_idx  = '0;
        for (int k = NUM_WORDS - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && (len_reg == LEN_W'(WORD_LEN[k])))
            begin
                id_hit  = 1'b1;
                id_idx  = 4'(k);
                id_kind = (k < NUM_KEYWORDS) ? KIND_KEYWORD : KIND_TYPE;
            end
        end
    end

    always_comb
    begin
        pre_close  = 1'b0;
        pre_kind   = KIND_IDENT;
        pre_idx    = '0;
        start_run  = 1'b0;
        put_req    = 1'b0;
        put_char   = c;
        post_close = 1'b0;
        post_kind  = KIND_OPERATOR;
        line_inc   = 1'b0;
        eof        = 1'b0;
        ident_step = 1'b0;
        mode_next  = mode_reg;
        op_next    = op_reg;

        if (src_data.end_of_input)
        begin
            eof        = 1'b1;
            mode_next  = M_IDLE;
            post_close = 1'b1;
            post_kind  = KIND_EOF;
            case (mode_reg)
                M_IDENT:
                begin
                    pre_close = 1'b1;
                    pre_kind  = id_kind;
                    pre_idx   = id_idx;
                end
                M_NUMBER:
                begin
                    pre_close = 1'b1;
                    pre_kind  = KIND_NUMBER;
                end
                M_STRING, M_ESCAPE:
                begin
                    pre_close = 1'b1;
                    pre_kind  = KIND_STRING;
                end
                M_OPERATOR:
                begin
                    pre_close = 1'b1;
                    pre_kind  = KIND_OPERATOR;
                end
                default: ;
            endcase
        end
        else
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"})
                    begin
                        put_req    = 1'b1;
                        ident_step = 1'b1;
                    end
                    else
                    begin
                        pre_close = 1'b1;
                        pre_kind  = id_kind;
                        pre_idx   = id_idx;
                        start_run = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (c inside {["0":"9"]})
                    begin
                        put_req = 1'b1;
                    end
                    else
                    begin
                        pre_close = 1'b1;
                        pre_kind  = KIND_NUMBER;
                        start_run = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (c == "\"")
                    begin
                        pre_close = 1'b1;
                        pre_kind  = KIND_STRING;
                        mode_next = M_IDLE;
                    end
                    else if (c == "\\")
                    begin
                        mode_next = M_ESCAPE;
                    end
                    else
                    begin
                        line_inc = (c == 8'h0a);
                        put_req  = 1'b1;
                    end
                end
                M_ESCAPE:
                begin
                    line_inc  = (c == 8'h0a);
                    put_req   = 1'b1;
                    put_char  = (c == "n") ? 8'h0a : ((c == "t") ? 8'h09 : c);
                    mode_next = M_STRING;
                end
                M_OPERATOR:
                begin
                    if (((op_reg == "&") && (c == "&")) || ((op_reg == "|") && (c == "|")) ||
                        ((op_reg != "&") && (op_reg != "|") && (c == "=")))
                    begin
                        put_req    = 1'b1;
                        post_close = 1'b1;
                        post_kind  = KIND_OPERATOR;
                        mode_next  = M_IDLE;
                    end
                    else
                    begin
                        pre_close = 1'b1;
                        pre_kind  = KIND_OPERATOR;
                        start_run = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (c == 8'h0a)
                    begin
                        line_inc  = 1'b1;
                        mode_next = M_IDLE;
                    end
                end
                default:
                begin
                    start_run = 1'b1;
                end
            endcase

            if (start_run)
            begin
                mode_next = M_IDLE;
                if (c inside {" ", [8'h09:8'h0d]})
                begin
                    line_inc = (c == 8'h0a);
                end
                else if (c inside {["a":"z"], ["A":"Z"], "_"})
                begin
                    mode_next  = M_IDENT;
                    put_req    = 1'b1;
                    ident_step = 1'b1;
                end
                else if (c inside {["0":"9"]})
                begin
                    mode_next = M_NUMBER;
                    put_req   = 1'b1;
                end
                else if (c == "\"")
                begin
                    mode_next = M_STRING;
                end
                else if (c inside {"&", "|", "=", "!", "<", ">"})
                begin
                    mode_next = M_OPERATOR;
                    put_req   = 1'b1;
                    op_next   = c;
                end
                else if (c inside {"+", "-", "*", "/"})
                begin
                    put_req    = 1'b1;
                    post_close = 1'b1;
                    post_kind  = KIND_OPERATOR;
                end
                else if (c inside {";", "(", ")", "{", "}", ","})
                begin
                    put_req    = 1'b1;
                    post_close = 1'b1;
                    post_kind  = KIND_SYMBOL;
                end
                else if (c == "#")
                begin
                    mode_next = M_COMMENT;
                end
            end
        end
    end

    always_comb
    begin
        len_base  = (pre_close || start_run || eof) ? '0 : len_reg;
        put_ok    = put_req && (len_base < LEN_W'(CAP));
        len_after = len_base + LEN_W'(put_ok);
        len_next  = post_close ? '0 : len_after;
        line_next = (line_inc && (line_reg != '1)) ? line_reg + LINE_BITS'(1) : line_reg;

        cand_base = start_run ? '1 : cand_reg;
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            cand_mask[k] = cand_base[k] && (len_base < LEN_W'(WORD_LEN[k])) &&
                           (WORD_TEXT[k][len_base[2:0]] == c);
        end
        cand_next = ident_step ? cand_mask : cand_reg;
    end

    always_comb
    begin
        line_wide     = 32'(line_reg);
        pre_len_wide  = 32'(len_reg);
        post_len_wide = 32'(len_after);
        bundle        = '0;
        n             = '0;
        if (pre_close)
        begin
            bundle.recs[n] = make_end(pre_kind, pre_len_wide[5:0], pre_idx, line_wide[15:0]);
            n = n + 2'd1;
        end
        if (put_ok)
        begin
            line_wide = 32'(line_next);
            bundle.recs[n] = make_text(put_char, line_wide[15:0]);
            n = n + 2'd1;
        end
        if (post_close)
        begin
            line_wide = 32'(line_next);
            bundle.recs[n] = make_end(post_kind, post_len_wide[5:0], 4'd0, line_wide[15:0]);
            n = n + 2'd1;
        end
        if (n != 2'd0)
        begin
            bundle.recs[n - 2'd1].last = 1'b1;
        end
        bundle.count = n;
    end

    assign q_push   = accept && (n != 2'd0);
    assign q_bundle = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            len_reg  <= '0;
            op_reg   <= '0;
            cand_reg <= '1;
            line_reg <= LINE_BITS'(1);
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            op_reg   <= op_next;
            cand_reg <= cand_next;
            line_reg <= line_next;
        end
    end

endmodule

// ===== rtl/core/stt_queue.sv =====
// ---------------------------------------------------------------------------
// Tokenizer bundle queue
// Short first-in first-out buffer of record bundles between front and back.
// ---------------------------------------------------------------------------
module stt_queue
    import stt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bundle_t     push_data,
    input  logic        pop,
    output bundle_t     head,
    output queue_stat_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/stt_back.sv =====
// ---------------------------------------------------------------------------
// Tokenizer back end
// Unpacks queued bundles into single records through the output register.
// ---------------------------------------------------------------------------
module stt_back
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bundle_t     head,
    input  queue_stat_t stat,
    output logic        pop,
    output logic        rec_valid,
    input  logic        rec_ready,
    output out_item_t   rec_data
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg;
    out_item_t  data_reg;
    logic       load;

    assign load     = !stat.empty && (!valid_reg || rec_ready);
    assign pop      = load && (idx_reg == (head.count - 2'd1));
    assign idx_next = pop ? 2'd0 : (load ? idx_reg + 2'd1 : idx_reg);

    assign rec_valid = valid_reg;
    assign rec_data  = data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= head.recs[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (rec_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/source_text_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexer: source bytes in, text and token-end records out.
// ---------------------------------------------------------------------------
// The src channel takes one source byte per cycle whenever the bundle queue
// has room; the lexer handles that byte in the same cycle and queues the one
// to three records it causes, if any, as one bundle. The rec channel gives one
// record per cycle from an output register while rec_ready is high and the
// queue is not empty, so the output port at one record per cycle sets the
// sustained rate. QUEUE_DEPTH bundles absorb bursts. No clearing pass after
// reset: the block takes bytes as soon as reset is released.
`include "assert_macros.svh"

module source_text_tokenizer_unit
    import stt_pkg::*;
#(
    parameter int MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF,
    parameter int LINE_BITS      = LINE_BITS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  in_item_t  src_data,
    output logic      rec_valid,
    input  logic      rec_ready,
    output out_item_t rec_data
);

    logic        q_push;
    logic        q_pop;
    bundle_t     q_bundle;
    bundle_t     q_head;
    queue_stat_t q_stat;

    stt_front #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
        .LINE_BITS      (LINE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .q_full    (q_stat.full),
        .q_push    (q_push),
        .q_bundle  (q_bundle)
    );

    stt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_bundle),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    stt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .stat      (q_stat),
        .pop       (q_pop),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec_data  (rec_data)
    );

    `STT_ASSERT_SAME(a_eof_is_last, rec_valid && rec_data.record_type && (rec_data.token_kind == KIND_EOF), rec_data.last, "end-of-file record not marked last")
    `STT_ASSERT_SAME(a_text_fields_clear, rec_valid && !rec_data.record_type, (rec_data.token_kind == KIND_IDENT) && (rec_data.token_length == 6'd0), "text record carries token fields")
    `STT_ASSERT_NEXT(a_eof_queued, src_valid && src_ready && src_data.end_of_input, !q_stat.empty, "end of input transfer left no bundle")
    `STT_ASSERT_SAME(a_no_push_full, q_stat.full, !q_push, "push into full queue")

endmodule
